### design/svsd_pkg.sv
// shared constants and types for the sparse vector store
package svsd_pkg;

    localparam int CAPACITY = 16;
    localparam int POS_BITS = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam logic [1:0] ACT_SET = 2'd0;
    localparam logic [1:0] ACT_GET = 2'd1;
    localparam logic [1:0] ACT_DOT = 2'd2;
    localparam logic [1:0] ACT_ADD = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [POS_BITS-1:0] pos;
        logic [31:0]         val;
    } entry_t;

endpackage

### design/sparse_vector_store_dot_add_top.sv
// sparse vector store with element set/get, dot product and vector add
//
//  channel | signals                                         | direction
//  in      | in_valid, in_stall, action, vector_sel,          | request in
//          | position, value                                 |
//  out     | out_valid, out_stall, status, result_position,   | results out
//          | result_value, last                              |
//
// one request at a time; each table step is a read state then an evaluate state
// on a memory with registered read data:
// set/get scan entries in order, insert or delete shift each moved entry,
// dot and add merge both tables; dot accumulates on matches, add waits on outputs.
// reset clears the counts and control; table contents stay undefined.
// a stalled output holds the state machine in its output state.
module sparse_vector_store_dot_add_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          action,
    input  logic                vector_sel,
    input  logic [15:0]         position,
    input  logic signed [31:0]  value,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [1:0]          status,
    output logic [15:0]         result_position,
    output logic signed [31:0]  result_value,
    output logic                last
);

    localparam int PW = svsd_pkg::POS_BITS;
    localparam int CW = svsd_pkg::CNT_W;
    localparam int IW = svsd_pkg::IDX_W;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SCAN  = 4'd1;
    localparam logic [3:0] S_SCANW = 4'd2;
    localparam logic [3:0] S_DEC   = 4'd3;
    localparam logic [3:0] S_DL    = 4'd4;
    localparam logic [3:0] S_DLW   = 4'd5;
    localparam logic [3:0] S_IN    = 4'd6;
    localparam logic [3:0] S_INW   = 4'd7;
    localparam logic [3:0] S_DOT   = 4'd8;
    localparam logic [3:0] S_DOTW  = 4'd9;
    localparam logic [3:0] S_DOTM  = 4'd10;
    localparam logic [3:0] S_ADD   = 4'd11;
    localparam logic [3:0] S_ADDW  = 4'd12;
    localparam logic [3:0] S_OUT   = 4'd13;

    svsd_pkg::entry_t mem_a [svsd_pkg::CAPACITY];
    svsd_pkg::entry_t mem_b [svsd_pkg::CAPACITY];
    svsd_pkg::entry_t rd_a, rd_b, rd_s, wd;
    logic [IW-1:0]    ra_a, ra_b, wa;
    logic             we_a, we_b;

    logic [3:0]    state_reg, state_next, ret_reg, ret_next;
    logic [1:0]    op_reg, op_next;
    logic          sel_reg, sel_next;
    logic [PW-1:0] p_reg, p_next;
    logic [31:0]   v_reg, v_next;
    logic [CW-1:0] cnt_a_reg, cnt_a_next, cnt_b_reg, cnt_b_next;
    logic [CW-1:0] ia_reg, ia_next, ib_reg, ib_next;
    logic [CW-1:0] idx_reg, idx_next, ins_reg, ins_next;
    logic          hit_reg, hit_next;
    logic [31:0]   hval_reg, hval_next;
    logic [31:0]   acc_reg, acc_next, prod_reg, prod_next;
    logic          pend_reg, pend_next;
    logic [PW-1:0] pend_pos_reg, pend_pos_next;
    logic [31:0]   pend_val_reg, pend_val_next;
    logic [1:0]    res_st_reg, res_st_next;
    logic [15:0]   res_pos_reg, res_pos_next;
    logic [31:0]   res_val_reg, res_val_next;
    logic          res_last_reg, res_last_next;
    logic          out_valid_reg, out_valid_next;
    logic [1:0]    status_reg, status_next;
    logic [15:0]   rpos_reg, rpos_next;
    logic [31:0]   rval_reg, rval_next;
    logic          last_reg, last_next;

    logic [CW-1:0] n_sel;
    logic [31:0]   p_ext, pin_ext, apos_ext, s_sum;
    logic [PW-1:0] pick;
    logic          va_ok, vb_ok, slot_free;

    always_ff @(posedge clk)
    begin
        if (we_a)
        begin
            mem_a[wa] <= wd;
        end
        if (we_b)
        begin
            mem_b[wa] <= wd;
        end
        rd_a <= mem_a[ra_a];
        rd_b <= mem_b[ra_b];
    end

    assign rd_s      = sel_reg ? rd_b : rd_a;
    assign n_sel     = sel_reg ? cnt_b_reg : cnt_a_reg;
    assign p_ext     = 32'(p_reg);
    assign pin_ext   = 32'(position);
    assign slot_free = !out_valid_reg || !out_stall;
    assign va_ok     = ia_reg < cnt_a_reg;
    assign vb_ok     = ib_reg < cnt_b_reg;
    assign pick      = (!vb_ok || (va_ok && rd_a.pos <= rd_b.pos)) ? rd_a.pos : rd_b.pos;
    assign s_sum     = ((va_ok && rd_a.pos == pick) ? rd_a.val : 32'd0)
                     + ((vb_ok && rd_b.pos == pick) ? rd_b.val : 32'd0);
    assign apos_ext  = 32'(pend_pos_reg);

    always_comb
    begin
        state_next    = state_reg;
        ret_next      = ret_reg;
        op_next       = op_reg;
        sel_next      = sel_reg;
        p_next        = p_reg;
        v_next        = v_reg;
        cnt_a_next    = cnt_a_reg;
        cnt_b_next    = cnt_b_reg;
        ia_next       = ia_reg;
        ib_next       = ib_reg;
        idx_next      = idx_reg;
        ins_next      = ins_reg;
        hit_next      = hit_reg;
        hval_next     = hval_reg;
        acc_next      = acc_reg;
        prod_next     = prod_reg;
        pend_next     = pend_reg;
        pend_pos_next = pend_pos_reg;
        pend_val_next = pend_val_reg;
        res_st_next   = res_st_reg;
        res_pos_next  = res_pos_reg;
        res_val_next  = res_val_reg;
        res_last_next = res_last_reg;
        out_valid_next = out_valid_reg && out_stall;
        status_next   = status_reg;
        rpos_next     = rpos_reg;
        rval_next     = rval_reg;
        last_next     = last_reg;
        ra_a = ia_reg[IW-1:0];
        ra_b = ib_reg[IW-1:0];
        wa   = idx_reg[IW-1:0];
        wd   = rd_s;
        we_a = 1'b0;
        we_b = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next  = action;
                    sel_next = vector_sel;
                    p_next   = pin_ext[PW-1:0];
                    v_next   = $unsigned(value);
                    idx_next = '0;
                    ia_next  = '0;
                    ib_next  = '0;
                    acc_next = '0;
                    pend_next = 1'b0;
                    case (action)
                        svsd_pkg::ACT_DOT: state_next = S_DOT;
                        svsd_pkg::ACT_ADD: state_next = S_ADD;
                        default:           state_next = S_SCAN;
                    endcase
                end
            end
            S_SCAN:
            begin
                ra_a = idx_reg[IW-1:0];
                ra_b = idx_reg[IW-1:0];
                if (idx_reg >= n_sel)
                begin
                    hit_next   = 1'b0;
                    state_next = S_DEC;
                end
                else
                begin
                    state_next = S_SCANW;
                end
            end
            S_SCANW:
            begin
                if (rd_s.pos >= p_reg)
                begin
                    hit_next   = rd_s.pos == p_reg;
                    hval_next  = rd_s.val;
                    state_next = S_DEC;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_DEC:
            begin
                ins_next      = idx_reg;
                res_pos_next  = p_ext[15:0];
                res_val_next  = '0;
                res_st_next   = svsd_pkg::ST_OK;
                res_last_next = 1'b1;
                ret_next      = S_IDLE;
                state_next    = S_OUT;
                if (op_reg == svsd_pkg::ACT_GET)
                begin
                    res_val_next = hit_reg ? hval_reg : 32'd0;
                end
                else if (hit_reg && v_reg != 32'd0)
                begin
                    wa   = idx_reg[IW-1:0];
                    wd   = '{pos: p_reg, val: v_reg};
                    we_a = !sel_reg;
                    we_b = sel_reg;
                end
                else if (hit_reg)
                begin
                    state_next = S_DL;
                end
                else if (v_reg == 32'd0)
                begin
                    // deleting an absent element is a no-op
                end
                else if (n_sel >= CW'(svsd_pkg::CAPACITY))
                begin
                    res_st_next = svsd_pkg::ST_FULL;
                end
                else
                begin
                    idx_next   = n_sel;
                    state_next = S_IN;
                end
            end
            S_DL:
            begin
                ra_a = IW'(idx_reg + 1'b1);
                ra_b = IW'(idx_reg + 1'b1);
                if (idx_reg + 1'b1 < n_sel)
                begin
                    state_next = S_DLW;
                end
                else
                begin
                    if (sel_reg)
                        cnt_b_next = cnt_b_reg - 1'b1;
                    else
                        cnt_a_next = cnt_a_reg - 1'b1;
                    state_next = S_OUT;
                end
            end
            S_DLW:
            begin
                wa       = idx_reg[IW-1:0];
                we_a     = !sel_reg;
                we_b     = sel_reg;
                idx_next = idx_reg + 1'b1;
                state_next = S_DL;
            end
            S_IN:
            begin
                ra_a = IW'(idx_reg - 1'b1);
                ra_b = IW'(idx_reg - 1'b1);
                if (idx_reg > ins_reg)
                begin
                    state_next = S_INW;
                end
                else
                begin
                    wa   = ins_reg[IW-1:0];
                    wd   = '{pos: p_reg, val: v_reg};
                    we_a = !sel_reg;
                    we_b = sel_reg;
                    if (sel_reg)
                        cnt_b_next = cnt_b_reg + 1'b1;
                    else
                        cnt_a_next = cnt_a_reg + 1'b1;
                    state_next = S_OUT;
                end
            end
            S_INW:
            begin
                wa       = idx_reg[IW-1:0];
                we_a     = !sel_reg;
                we_b     = sel_reg;
                idx_next = idx_reg - 1'b1;
                state_next = S_IN;
            end
            S_DOT:
            begin
                if (va_ok && vb_ok)
                begin
                    state_next = S_DOTW;
                end
                else
                begin
                    res_st_next   = svsd_pkg::ST_OK;
                    res_pos_next  = '0;
                    res_val_next  = acc_reg;
                    res_last_next = 1'b1;
                    ret_next      = S_IDLE;
                    state_next    = S_OUT;
                end
            end
            S_DOTW:
            begin
                if (rd_a.pos == rd_b.pos)
                begin
                    prod_next  = rd_a.val * rd_b.val;
                    ia_next    = ia_reg + 1'b1;
                    ib_next    = ib_reg + 1'b1;
                    state_next = S_DOTM;
                end
                else if (rd_a.pos > rd_b.pos)
                begin
                    ib_next    = ib_reg + 1'b1;
                    state_next = S_DOT;
                end
                else
                begin
                    ia_next    = ia_reg + 1'b1;
                    state_next = S_DOT;
                end
            end
            S_DOTM:
            begin
                acc_next   = acc_reg + prod_reg;
                state_next = S_DOT;
            end
            S_ADD:
            begin
                if (va_ok || vb_ok)
                begin
                    state_next = S_ADDW;
                end
                else
                begin
                    res_st_next   = pend_reg ? svsd_pkg::ST_OK : svsd_pkg::ST_EMPTY;
                    res_pos_next  = pend_reg ? apos_ext[15:0] : 16'd0;
                    res_val_next  = pend_reg ? pend_val_reg : 32'd0;
                    res_last_next = 1'b1;
                    ret_next      = S_IDLE;
                    state_next    = S_OUT;
                end
            end
            S_ADDW:
            begin
                if (va_ok && rd_a.pos == pick)
                    ia_next = ia_reg + 1'b1;
                if (vb_ok && rd_b.pos == pick)
                    ib_next = ib_reg + 1'b1;
                state_next = S_ADD;
                if (s_sum != 32'd0)
                begin
                    // hold one sum back so the final one can carry last
                    if (pend_reg)
                    begin
                        res_st_next   = svsd_pkg::ST_OK;
                        res_pos_next  = apos_ext[15:0];
                        res_val_next  = pend_val_reg;
                        res_last_next = 1'b0;
                        ret_next      = S_ADD;
                        state_next    = S_OUT;
                    end
                    pend_next     = 1'b1;
                    pend_pos_next = pick;
                    pend_val_next = s_sum;
                end
            end
            S_OUT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = res_st_reg;
                    rpos_next      = res_pos_reg;
                    rval_next      = res_val_reg;
                    last_next      = res_last_reg;
                    state_next     = ret_reg;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            cnt_a_reg     <= '0;
            cnt_b_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            cnt_a_reg     <= cnt_a_next;
            cnt_b_reg     <= cnt_b_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        sel_reg      <= sel_next;
        p_reg        <= p_next;
        v_reg        <= v_next;
        ia_reg       <= ia_next;
        ib_reg       <= ib_next;
        idx_reg      <= idx_next;
        ins_reg      <= ins_next;
        hit_reg      <= hit_next;
        hval_reg     <= hval_next;
        acc_reg      <= acc_next;
        prod_reg     <= prod_next;
        pend_pos_reg <= pend_pos_next;
        pend_val_reg <= pend_val_next;
        res_st_reg   <= res_st_next;
        res_pos_reg  <= res_pos_next;
        res_val_reg  <= res_val_next;
        res_last_reg <= res_last_next;
        status_reg   <= status_next;
        rpos_reg     <= rpos_next;
        rval_reg     <= rval_next;
        last_reg     <= last_next;
    end

    assign in_stall        = state_reg != S_IDLE;
    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign result_position = rpos_reg;
    assign result_value    = $signed(rval_reg);
    assign last            = last_reg;

`ifndef SYNTH
    a_cnt_a_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_a_reg <= CW'(svsd_pkg::CAPACITY))
        else $error("count of table a beyond capacity");
    a_cnt_b_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_b_reg <= CW'(svsd_pkg::CAPACITY))
        else $error("count of table b beyond capacity");
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> state_reg != S_IDLE)
        else $error("request accepted but block not busy");
    a_one_table_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(we_a && we_b))
        else $error("both tables written in one cycle");
`endif

endmodule
